// ----- rtl/cfpv_pkg.sv -----
// Package for the phase-velocity stencil: grid geometry, fixed-point widths,
// payload structs, controller states and the controller/datapath command bundle.
// No dependencies.
`default_nettype none

package cfpv_pkg;

  // Grid geometry (the edge fills its coordinate bits exactly; address is the packed {x, y, z})
  localparam int GRID_SIZE  = 64;
  localparam int COORD_W    = $clog2(GRID_SIZE);
  localparam int CELL_AW    = 3 * COORD_W;
  localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  // Fixed-point widths
  localparam int SAMPLE_W  = 16;                 // Q2.14 component
  localparam int WORD_W    = 2 * SAMPLE_W;       // imag in high half, real in low half
  localparam int DIFF_W    = SAMPLE_W + 1;       // next - prev
  localparam int PROD_W    = DIFF_W + SAMPLE_W;  // one stencil product
  localparam int NUM_W     = PROD_W + 1;         // difference of two products
  localparam int DEN_W     = 2 * SAMPLE_W;       // cr^2 + ci^2
  localparam int MAG_W     = 2 * SAMPLE_W;       // |num|
  localparam int GRAD_FRAC = 12;                 // Q12 gradient
  localparam int QUO_W     = MAG_W + GRAD_FRAC;  // dividend and quotient
  localparam int DIV_BITS  = 4;                  // quotient bits per cycle
  localparam int HALF_W    = QUO_W / 2;
  localparam int GAIN_W    = 24;
  localparam int GPROD_W   = HALF_W + GAIN_W;
  localparam int FULL_W    = QUO_W + GAIN_W;
  localparam int VEL_W     = 32;
  localparam int NSLOT     = 7;                  // centre plus six neighbors
  localparam int NLANE     = 3;                  // x, y, z

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4096);

  // Sequencer counts
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(NSLOT);
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(2 + 2 * NLANE);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W / DIV_BITS - 1);
  localparam logic [CNT_W-1:0] MULG_LAST = CNT_W'(2 * NLANE);

  // Read slots
  localparam logic [2:0] SLOT_C  = 3'd0;
  localparam logic [2:0] SLOT_XP = 3'd1;
  localparam logic [2:0] SLOT_XM = 3'd2;
  localparam logic [2:0] SLOT_YP = 3'd3;
  localparam logic [2:0] SLOT_YM = 3'd4;
  localparam logic [2:0] SLOT_ZP = 3'd5;
  localparam logic [2:0] SLOT_ZM = 3'd6;

  // Stencil product order: centre energy first, then (di*cr, dr*ci) per axis
  localparam logic [2:0] MI_CRR = 3'd0;
  localparam logic [2:0] MI_CII = 3'd1;
  localparam logic [2:0] MI_AX0 = 3'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } cfpv_op_t;

  typedef struct packed {
    cfpv_op_t                    command;
    logic [5:0]                  x_index;
    logic [5:0]                  y_index;
    logic [5:0]                  z_index;
    logic signed [SAMPLE_W-1:0]  sample_real;
    logic signed [SAMPLE_W-1:0]  sample_imag;
  } cfpv_in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
    logic                    zero_amplitude;
  } cfpv_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DIVL,
    ST_DIV,
    ST_MULG,
    ST_OUT
  } cfpv_state_t;

  typedef struct packed {
    logic       wr_en;
    logic       capture;
    logic       rd_en;
    logic [2:0] rd_slot;
    logic       mul_go;
    logic [2:0] mul_idx;
    logic       div_load;
    logic       div_step;
    logic       gmul_go;
    logic [2:0] gmul_idx;
    logic       out_load;
  } cfpv_cmd_t;

  typedef struct packed {
    logic den_zero;
  } cfpv_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cfpv_ctrl.sv -----
// Controller for the phase-velocity stencil: sequences reads, products,
// division, gain scaling and result hand-off. Depends on cfpv_pkg.
`default_nettype none

module cfpv_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_query,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  input  wire cfpv_pkg::cfpv_stat_t stat,
  output cfpv_pkg::cfpv_cmd_t      cmd
);

  cfpv_pkg::cfpv_state_t           state, state_next;
  logic [cfpv_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic                            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != cfpv_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfpv_pkg::ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      cfpv_pkg::ST_IDLE: begin
        cnt_next = '0;
        if (in_valid && in_query) begin
          state_next = cfpv_pkg::ST_READ;
        end
      end
      cfpv_pkg::ST_READ: begin
        if (cnt == cfpv_pkg::READ_LAST) begin
          state_next = cfpv_pkg::ST_MUL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      cfpv_pkg::ST_MUL: begin
        if (cnt == cfpv_pkg::MUL_LAST) begin
          state_next = cfpv_pkg::ST_DIVL;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      cfpv_pkg::ST_DIVL: begin
        cnt_next   = '0;
        state_next = stat.den_zero ? cfpv_pkg::ST_OUT : cfpv_pkg::ST_DIV;
      end
      cfpv_pkg::ST_DIV: begin
        if (cnt == cfpv_pkg::DIV_LAST) begin
          state_next = cfpv_pkg::ST_MULG;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      cfpv_pkg::ST_MULG: begin
        if (cnt == cfpv_pkg::MULG_LAST) begin
          state_next = cfpv_pkg::ST_OUT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      cfpv_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = cfpv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cfpv_pkg::ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      cfpv_pkg::ST_IDLE: begin
        cmd.wr_en   = in_valid && !in_query;
        cmd.capture = in_valid && in_query;
      end
      cfpv_pkg::ST_READ: begin
        cmd.rd_en   = (cnt < cfpv_pkg::READ_LAST);
        cmd.rd_slot = cnt[2:0];
      end
      cfpv_pkg::ST_MUL: begin
        cmd.mul_go  = (cnt < cfpv_pkg::MUL_LAST);
        cmd.mul_idx = cnt[2:0];
      end
      cfpv_pkg::ST_DIVL: begin
        cmd.div_load = 1'b1;
      end
      cfpv_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      cfpv_pkg::ST_MULG: begin
        cmd.gmul_go  = (cnt < cfpv_pkg::MULG_LAST);
        cmd.gmul_idx = cnt[2:0];
      end
      cfpv_pkg::ST_OUT: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/cfpv_dp.sv -----
// Datapath for the phase-velocity stencil: grid memory, stencil multiplier,
// three-lane divider, gain multiplier and output register. Depends on cfpv_pkg.
`default_nettype none

module cfpv_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire cfpv_pkg::cfpv_cmd_t       cmd,
  output cfpv_pkg::cfpv_stat_t           stat,
  input  wire cfpv_pkg::cfpv_in_t        in_data,
  input  wire logic                      cfg_we,
  input  wire logic [cfpv_pkg::GAIN_W-1:0] cfg_wdata,
  output cfpv_pkg::cfpv_out_t            out_data
);

  localparam int CW = cfpv_pkg::COORD_W;
  localparam int SW = cfpv_pkg::SAMPLE_W;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
    return (c == CW'(cfpv_pkg::GRID_SIZE - 1)) ? '0 : c + 1'b1;
  endfunction

  function automatic logic [CW-1:0] wrap_dec(input logic [CW-1:0] c);
    return (c == '0) ? CW'(cfpv_pkg::GRID_SIZE - 1) : c - 1'b1;
  endfunction

  // DIV_BITS restoring steps; returns {remainder, quotient/dividend}
  function automatic logic [cfpv_pkg::DEN_W+cfpv_pkg::QUO_W-1:0] div_iter(
    input logic [cfpv_pkg::DEN_W-1:0] r_in,
    input logic [cfpv_pkg::QUO_W-1:0] q_in,
    input logic [cfpv_pkg::DEN_W-1:0] d
  );
    logic [cfpv_pkg::DEN_W:0]   r2;
    logic [cfpv_pkg::DEN_W-1:0] r;
    logic [cfpv_pkg::QUO_W-1:0] q;
    r = r_in;
    q = q_in;
    for (int i = 0; i < cfpv_pkg::DIV_BITS; i++) begin
      r2 = {r, q[cfpv_pkg::QUO_W-1]};
      q  = {q[cfpv_pkg::QUO_W-2:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
        r2   = r2 - {1'b0, d};
        q[0] = 1'b1;
      end
      r = r2[cfpv_pkg::DEN_W-1:0];
    end
    return {r, q};
  endfunction

  function automatic logic signed [cfpv_pkg::VEL_W-1:0] finish(
    input logic n,
    input logic s,
    input logic [cfpv_pkg::VEL_W-2:0] m
  );
    if (s) begin
      return n ? {1'b1, {(cfpv_pkg::VEL_W-1){1'b0}}} : {1'b0, {(cfpv_pkg::VEL_W-1){1'b1}}};
    end
    return n ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Configuration and query coordinates
  logic [cfpv_pkg::GAIN_W-1:0] gain;
  logic [CW-1:0]               xq, yq, zq;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= cfpv_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xq <= in_data.x_index[CW-1:0];
      yq <= in_data.y_index[CW-1:0];
      zq <= in_data.z_index[CW-1:0];
    end
  end

  // Grid memory, single port
  logic [cfpv_pkg::WORD_W-1:0]  grid_mem [cfpv_pkg::CELL_COUNT];
  logic [cfpv_pkg::WORD_W-1:0]  rd_data;
  logic [cfpv_pkg::CELL_AW-1:0] rd_addr, wr_addr, mem_addr;

  always_comb begin
    unique case (cmd.rd_slot)
      cfpv_pkg::SLOT_XP: rd_addr = {wrap_inc(xq), yq, zq};
      cfpv_pkg::SLOT_XM: rd_addr = {wrap_dec(xq), yq, zq};
      cfpv_pkg::SLOT_YP: rd_addr = {xq, wrap_inc(yq), zq};
      cfpv_pkg::SLOT_YM: rd_addr = {xq, wrap_dec(yq), zq};
      cfpv_pkg::SLOT_ZP: rd_addr = {xq, yq, wrap_inc(zq)};
      cfpv_pkg::SLOT_ZM: rd_addr = {xq, yq, wrap_dec(zq)};
      default:           rd_addr = {xq, yq, zq};
    endcase
  end

  assign wr_addr  = {in_data.x_index[CW-1:0], in_data.y_index[CW-1:0],
                     in_data.z_index[CW-1:0]};
  assign mem_addr = cmd.wr_en ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      grid_mem[mem_addr] <= {in_data.sample_imag, in_data.sample_real};
    end else if (cmd.rd_en) begin
      rd_data <= grid_mem[mem_addr];
    end
  end

  // Gather the seven stencil words
  logic                        rd_pend;
  logic [2:0]                  rd_slot_q;
  logic [cfpv_pkg::WORD_W-1:0] slot_word [cfpv_pkg::NSLOT];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_slot_q <= cmd.rd_slot;
    if (rd_pend) begin
      slot_word[rd_slot_q] <= rd_data;
    end
  end

  // Stencil products: one signed multiply per cycle
  logic signed [SW-1:0]               cr, ci, nr, ni, pr, pi;
  logic signed [cfpv_pkg::DIFF_W-1:0] dr, di, mul_a;
  logic signed [SW-1:0]               mul_b;
  logic [2:0]                         m_off, p_off;
  logic [1:0]                         m_axis, p_axis;
  logic signed [cfpv_pkg::PROD_W-1:0] prod;
  logic                               prod_vld;
  logic [2:0]                         prod_idx;
  logic [cfpv_pkg::DEN_W-1:0]         den;
  logic signed [cfpv_pkg::NUM_W-1:0]  num [cfpv_pkg::NLANE];

  assign cr     = slot_word[cfpv_pkg::SLOT_C][SW-1:0];
  assign ci     = slot_word[cfpv_pkg::SLOT_C][2*SW-1:SW];
  assign m_off  = cmd.mul_idx - cfpv_pkg::MI_AX0;
  assign m_axis = m_off[2:1];
  assign p_off  = prod_idx - cfpv_pkg::MI_AX0;
  assign p_axis = p_off[2:1];

  always_comb begin
    unique case (m_axis)
      2'd0: begin
        nr = slot_word[cfpv_pkg::SLOT_XP][SW-1:0];
        ni = slot_word[cfpv_pkg::SLOT_XP][2*SW-1:SW];
        pr = slot_word[cfpv_pkg::SLOT_XM][SW-1:0];
        pi = slot_word[cfpv_pkg::SLOT_XM][2*SW-1:SW];
      end
      2'd1: begin
        nr = slot_word[cfpv_pkg::SLOT_YP][SW-1:0];
        ni = slot_word[cfpv_pkg::SLOT_YP][2*SW-1:SW];
        pr = slot_word[cfpv_pkg::SLOT_YM][SW-1:0];
        pi = slot_word[cfpv_pkg::SLOT_YM][2*SW-1:SW];
      end
      default: begin
        nr = slot_word[cfpv_pkg::SLOT_ZP][SW-1:0];
        ni = slot_word[cfpv_pkg::SLOT_ZP][2*SW-1:SW];
        pr = slot_word[cfpv_pkg::SLOT_ZM][SW-1:0];
        pi = slot_word[cfpv_pkg::SLOT_ZM][2*SW-1:SW];
      end
    endcase
  end

  assign dr = {nr[SW-1], nr} - {pr[SW-1], pr};
  assign di = {ni[SW-1], ni} - {pi[SW-1], pi};

  always_comb begin
    priority if (cmd.mul_idx == cfpv_pkg::MI_CRR) begin
      mul_a = {cr[SW-1], cr};
      mul_b = cr;
    end else if (cmd.mul_idx == cfpv_pkg::MI_CII) begin
      mul_a = {ci[SW-1], ci};
      mul_b = ci;
    end else if (!cmd.mul_idx[0]) begin
      mul_a = di;
      mul_b = cr;
    end else begin
      mul_a = dr;
      mul_b = ci;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod_idx <= cmd.mul_idx;
    if (cmd.mul_go) begin
      prod <= mul_a * mul_b;
    end
    if (prod_vld) begin
      priority if (prod_idx == cfpv_pkg::MI_CRR) begin
        den <= prod[cfpv_pkg::DEN_W-1:0];
      end else if (prod_idx == cfpv_pkg::MI_CII) begin
        den <= den + prod[cfpv_pkg::DEN_W-1:0];
      end else if (!prod_idx[0]) begin
        num[p_axis] <= {prod[cfpv_pkg::PROD_W-1], prod};
      end else begin
        num[p_axis] <= num[p_axis] - {prod[cfpv_pkg::PROD_W-1], prod};
      end
    end
  end

  assign stat.den_zero = (den == '0);

  // Three-lane divider: (|num| << GRAD_FRAC) / den
  logic                        zero_q;
  logic                        neg [cfpv_pkg::NLANE];
  logic [cfpv_pkg::DEN_W-1:0]  rem [cfpv_pkg::NLANE];
  logic [cfpv_pkg::QUO_W-1:0]  quo [cfpv_pkg::NLANE];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      zero_q <= stat.den_zero;
    end
  end

  for (genvar l = 0; l < cfpv_pkg::NLANE; l++) begin : g_lane
    logic [cfpv_pkg::NUM_W-1:0]                   mag;
    logic [cfpv_pkg::DEN_W+cfpv_pkg::QUO_W-1:0]   step;

    assign mag  = num[l][cfpv_pkg::NUM_W-1] ? -num[l] : num[l];
    assign step = div_iter(rem[l], quo[l], den);

    always_ff @(posedge clk) begin
      if (cmd.div_load) begin
        neg[l] <= num[l][cfpv_pkg::NUM_W-1];
        rem[l] <= '0;
        quo[l] <= {mag[cfpv_pkg::MAG_W-1:0], {cfpv_pkg::GRAD_FRAC{1'b0}}};
      end else if (cmd.div_step) begin
        rem[l] <= step[cfpv_pkg::DEN_W+cfpv_pkg::QUO_W-1:cfpv_pkg::QUO_W];
        quo[l] <= step[cfpv_pkg::QUO_W-1:0];
      end
    end
  end

  // Gain scaling: quotient halves times gain, one product per cycle
  logic [1:0]                    g_lane_sel, gp_lane;
  logic [cfpv_pkg::HALF_W-1:0]   g_op;
  logic [cfpv_pkg::GPROD_W-1:0]  gprod, acc_low;
  logic                          gprod_vld;
  logic [2:0]                    gprod_idx;
  logic [cfpv_pkg::FULL_W-1:0]   full;
  logic [cfpv_pkg::VEL_W-2:0]    vmag [cfpv_pkg::NLANE];
  logic                          sat  [cfpv_pkg::NLANE];

  assign g_lane_sel = cmd.gmul_idx[2:1];
  assign g_op       = cmd.gmul_idx[0] ? quo[g_lane_sel][cfpv_pkg::QUO_W-1:cfpv_pkg::HALF_W]
                                      : quo[g_lane_sel][cfpv_pkg::HALF_W-1:0];
  assign gp_lane    = gprod_idx[2:1];
  assign full       = {{(cfpv_pkg::FULL_W-cfpv_pkg::GPROD_W){1'b0}}, acc_low}
                    + {gprod, {cfpv_pkg::HALF_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      gprod_vld <= 1'b0;
    end else begin
      gprod_vld <= cmd.gmul_go;
    end
  end

  always_ff @(posedge clk) begin
    gprod_idx <= cmd.gmul_idx;
    if (cmd.gmul_go) begin
      gprod <= g_op * gain;
    end
    if (gprod_vld) begin
      if (!gprod_idx[0]) begin
        acc_low <= gprod;
      end else begin
        vmag[gp_lane] <= full[cfpv_pkg::GRAD_FRAC+cfpv_pkg::VEL_W-2:cfpv_pkg::GRAD_FRAC];
        sat[gp_lane]  <= |full[cfpv_pkg::FULL_W-1:cfpv_pkg::GRAD_FRAC+cfpv_pkg::VEL_W-1];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.zero_amplitude <= zero_q;
      out_data.vel_x <= zero_q ? '0 : finish(neg[0], sat[0], vmag[0]);
      out_data.vel_y <= zero_q ? '0 : finish(neg[1], sat[1], vmag[1]);
      out_data.vel_z <= zero_q ? '0 : finish(neg[2], sat[2], vmag[2]);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/complex_field_phase_velocity_stencil.sv -----
// Top level of the phase-velocity stencil over a periodic complex grid.
// Joins cfpv_ctrl and cfpv_dp; depends on cfpv_pkg.
//
//  channel  | handshake             | payload       | transfer when
//  ---------+-----------------------+---------------+--------------------------
//  input    | in_valid / in_stall   | cfpv_in_t     | in_valid && !in_stall
//  output   | out_valid / out_stall | cfpv_out_t    | out_valid && !out_stall
//  config   | cfg_we                | cfg_wdata     | cfg_we
//
// Writes transfer while idle and can follow each other every cycle. A query holds the
// input until its result is loaded (a zero centre skips the divider and gain products):
// seven reads on the single-port grid, eight products on one 17x16 multiplier, a divider
// taking four quotient bits per cycle in three lanes, six products on one 22x24.
// Reset is synchronous: clear the sequencer and valid flags, set the gain to 4096; the grid
// is not cleared. Hold a stalled result; writes still transfer, a query waits to load it.
`default_nettype none

module complex_field_phase_velocity_stencil (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire cfpv_pkg::cfpv_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output cfpv_pkg::cfpv_out_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [cfpv_pkg::GAIN_W-1:0] cfg_wdata
);

  cfpv_pkg::cfpv_cmd_t  cmd;
  cfpv_pkg::cfpv_stat_t stat;
  logic                 in_query;

  // Decode the command of the offered item; only looked at while idle
  assign in_query = (in_data.command == cfpv_pkg::OP_QUERY);

  // Sequencer: owns the handshakes and steps the datapath
  cfpv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_query  (in_query),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Grid store, arithmetic and result register
  cfpv_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // A query transfer must close the input until its result is formed
  a_query_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_query) |=> in_stall)
    else $error("input open right after a query transfer");

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register loaded while held");

  // A zero centre forces all three velocities to zero
  a_zero_amp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.zero_amplitude) |->
      (out_data.vel_x == '0 && out_data.vel_y == '0 && out_data.vel_z == '0))
    else $error("nonzero velocity with zero amplitude flag");

  // Grid writes only happen on an accepted write command
  a_write_gate: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (in_valid && !in_stall && !in_query))
    else $error("grid write without a write transfer");
`endif

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
// Self-checking bench for complex_field_phase_velocity_stencil: a mirror of the grid and
// gain predicts every query result, which is checked against the output channel in order.
// Depends on cfpv_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;

  localparam int COORD_W   = cfpv_pkg::COORD_W;
  localparam int CELL_AW   = cfpv_pkg::CELL_AW;
  localparam int SAMPLE_W  = cfpv_pkg::SAMPLE_W;
  localparam int WORD_W    = cfpv_pkg::WORD_W;
  localparam int GAIN_W    = cfpv_pkg::GAIN_W;
  localparam int VEL_W     = cfpv_pkg::VEL_W;
  localparam int GRAD_FRAC = cfpv_pkg::GRAD_FRAC;

  localparam int PHASE_ITEMS  = 280;   // commands per random phase
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES = 50;    // margin after the queues drain, before the next gain change
  localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer before giving up

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  cfpv_pkg::cfpv_in_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  cfpv_pkg::cfpv_out_t out_data;
  logic                cfg_we = 1'b0;
  logic [GAIN_W-1:0]   cfg_wdata = '0;

  complex_field_phase_velocity_stencil dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Commands waiting to be offered, and velocities waiting to come out.
  cfpv_pkg::cfpv_in_t  pending_cmds[$];
  cfpv_pkg::cfpv_out_t velocity_due[$];
  // Grid points whose whole seven-point stencil has been written at least once.
  logic [CELL_AW-1:0] ready_pts[$];
  // Mirror of the grid memory, keyed by the packed {x, y, z} address.
  logic [WORD_W-1:0] grid_copy[logic [CELL_AW-1:0]];
  logic [GAIN_W-1:0] gain_now = cfpv_pkg::GAIN_RESET;

  int fail_count     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;
  bit in_taken       = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Grid geometry and stimulus helpers
  // ---------------------------------------------------------------------------

  // Address of one stencil slot around point p; 6-bit coordinates wrap on their own,
  // which is exactly the periodic boundary of a 64-point edge.
  function automatic logic [CELL_AW-1:0] stencil_cell(logic [CELL_AW-1:0] p, logic [2:0] slot);
    logic [COORD_W-1:0] x, y, z;
    {x, y, z} = p;
    case (slot)
      cfpv_pkg::SLOT_XP: x = x + 1'b1;
      cfpv_pkg::SLOT_XM: x = x - 1'b1;
      cfpv_pkg::SLOT_YP: y = y + 1'b1;
      cfpv_pkg::SLOT_YM: y = y - 1'b1;
      cfpv_pkg::SLOT_ZP: z = z + 1'b1;
      cfpv_pkg::SLOT_ZM: z = z - 1'b1;
      default: ;
    endcase
    return {x, y, z};
  endfunction

  // Lean on the grid faces so wrap-around neighbors get hit often.
  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return COORD_W'($urandom);
  endfunction

  // Extremes, tiny values (big gradients, saturation) and full-range noise.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'sh8000;
    if (r < 20) return 16'sh7FFF;
    if (r < 35) return SAMPLE_W'(int'($urandom_range(8)) - 4);
    if (r < 40) return '0;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic add_write(input logic [CELL_AW-1:0] a, input logic signed [SAMPLE_W-1:0] re,
                           input logic signed [SAMPLE_W-1:0] im);
    cfpv_pkg::cfpv_in_t it;
    it.command = cfpv_pkg::OP_WRITE;
    {it.x_index, it.y_index, it.z_index} = a;
    it.sample_real = re;
    it.sample_imag = im;
    pending_cmds.push_back(it);
  endtask

  task automatic add_query(input logic [CELL_AW-1:0] a);
    cfpv_pkg::cfpv_in_t it;
    it.command = cfpv_pkg::OP_QUERY;
    {it.x_index, it.y_index, it.z_index} = a;
    // sample fields are unused on a query; fill them with noise
    it.sample_real = SAMPLE_W'($urandom);
    it.sample_imag = SAMPLE_W'($urandom);
    pending_cmds.push_back(it);
  endtask

  // Write a full stencil (given centre, random neighbors) and query its centre.
  task automatic add_stencil(input logic [CELL_AW-1:0] p, input logic signed [SAMPLE_W-1:0] cre,
                             input logic signed [SAMPLE_W-1:0] cim);
    add_write(p, cre, cim);
    for (int s = cfpv_pkg::SLOT_XP; s <= cfpv_pkg::SLOT_ZM; s++)
      add_write(stencil_cell(p, 3'(s)), pick_sample(), pick_sample());
    add_query(p);
    ready_pts.push_back(p);
  endtask

  // Mostly well-formed stencil/query sequences, some re-queries and partial rewrites
  // of known points, and a share of stray writes anywhere in the grid.
  task automatic plan_random(input int target);
    int r;
    logic [CELL_AW-1:0] p;
    while (pending_cmds.size() < target) begin
      r = $urandom_range(99);
      if (r < 45 || ready_pts.size() == 0) begin
        p = {pick_coord(), pick_coord(), pick_coord()};
        if ($urandom_range(99) < 6) add_stencil(p, '0, '0);
        else add_stencil(p, pick_sample(), pick_sample());
      end else if (r < 70) begin
        add_query(ready_pts[$urandom_range(ready_pts.size() - 1)]);
      end else if (r < 85) begin
        p = ready_pts[$urandom_range(ready_pts.size() - 1)];
        add_write(stencil_cell(p, 3'($urandom_range(6))), pick_sample(), pick_sample());
        add_query(p);
      end else begin
        add_write(CELL_AW'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
      end
    end
  endtask

  // Wait until everything offered has gone through and every result is back, then
  // let the block finish any trailing write before the next register change.
  task automatic settle();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || in_valid || velocity_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [GAIN_W-1:0] gain, input int send_pct,
                           input int stall_pct, input bit pressure);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= gain;
    @(negedge clk);
    cfg_we <= 1'b0;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    plan_random(PHASE_ITEMS);
    // hold the output side off while the sender keeps offering, so the block backs up
    if (pressure) hold_arm = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Velocity predictor
  // ---------------------------------------------------------------------------

  function automatic logic [WORD_W-1:0] cell_word(logic [CELL_AW-1:0] a);
    return grid_copy.exists(a) ? grid_copy[a] : '0;
  endfunction

  // Im((next - prev) * conj(c)) / |c|^2 in Q12, times gain in Q12, sign applied last,
  // saturated to 32 bits.
  function automatic logic [VEL_W-1:0] axis_velocity(logic [WORD_W-1:0] nxt,
                                                     logic [WORD_W-1:0] prv,
                                                     logic signed [SAMPLE_W-1:0] cr,
                                                     logic signed [SAMPLE_W-1:0] ci,
                                                     longint unsigned den);
    longint dr, di, num;
    longint unsigned mag, grad, vmag;
    dr  = longint'($signed(nxt[15:0])) - longint'($signed(prv[15:0]));
    di  = longint'($signed(nxt[31:16])) - longint'($signed(prv[31:16]));
    num = di * longint'(cr) - dr * longint'(ci);
    mag = (num < 0) ? -num : num;
    grad = (mag << GRAD_FRAC) / den;
    if (gain_now != 0 && grad > 64'h7FFF_FFFF_FFFF_FFFF / gain_now) vmag = '1;
    else vmag = (grad * gain_now) >> GRAD_FRAC;
    if (num < 0) return (vmag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-vmag);
    return (vmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : vmag[31:0];
  endfunction

  function automatic cfpv_pkg::cfpv_out_t predict_velocity(logic [CELL_AW-1:0] p);
    logic [WORD_W-1:0] c;
    logic signed [SAMPLE_W-1:0] cr, ci;
    longint unsigned den;
    cfpv_pkg::cfpv_out_t v;
    c   = cell_word(p);
    cr  = c[15:0];
    ci  = c[31:16];
    den = longint'(cr) * longint'(cr) + longint'(ci) * longint'(ci);
    v   = '0;
    if (den == 0) begin
      v.zero_amplitude = 1'b1;
    end else begin
      v.vel_x = axis_velocity(cell_word(stencil_cell(p, cfpv_pkg::SLOT_XP)),
                              cell_word(stencil_cell(p, cfpv_pkg::SLOT_XM)), cr, ci, den);
      v.vel_y = axis_velocity(cell_word(stencil_cell(p, cfpv_pkg::SLOT_YP)),
                              cell_word(stencil_cell(p, cfpv_pkg::SLOT_YM)), cr, ci, den);
      v.vel_z = axis_velocity(cell_word(stencil_cell(p, cfpv_pkg::SLOT_ZP)),
                              cell_word(stencil_cell(p, cfpv_pkg::SLOT_ZM)), cr, ci, den);
    end
    return v;
  endfunction

  task automatic check_velocity(input cfpv_pkg::cfpv_out_t got);
    cfpv_pkg::cfpv_out_t want;
    if (velocity_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: vx=%0d vy=%0d vz=%0d zero=%0b",
                 got.vel_x, got.vel_y, got.vel_z, got.zero_amplitude);
    end else begin
      want = velocity_due.pop_front();
      if (got.vel_x !== want.vel_x || got.vel_y !== want.vel_y ||
          got.vel_z !== want.vel_z || got.zero_amplitude !== want.zero_amplitude) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"mismatch: expected vx=%0d vy=%0d vz=%0d zero=%0b,",
                    " got vx=%0d vy=%0d vz=%0d zero=%0b"},
                   want.vel_x, want.vel_y, want.vel_z, want.zero_amplitude,
                   got.vel_x, got.vel_y, got.vel_z, got.zero_amplitude);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge; hold a stalled transfer unchanged.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when armed, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_arm) begin
      hold_arm  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, mirror writes and gain, predict queries,
  // check results, and watch for a stuck pipeline.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
      gain_now = cfpv_pkg::GAIN_RESET;
      quiet_cycles = 0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_we) gain_now = cfg_wdata;
      if (out_valid && !out_stall) check_velocity(out_data);
      if (in_valid && !in_stall) begin
        if (in_data.command == cfpv_pkg::OP_WRITE)
          grid_copy[{in_data.x_index, in_data.y_index, in_data.z_index}] =
            {in_data.sample_imag, in_data.sample_real};
        else
          velocity_due.push_back(
            predict_velocity({in_data.x_index, in_data.y_index, in_data.z_index}));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, a directed phase at the reset gain, then random phases that
  // each set a new gain and a new idling pattern.
  // ---------------------------------------------------------------------------
  initial begin
    logic [CELL_AW-1:0] origin, corner;
    origin = '0;
    corner = '1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stencil at the origin: every neighbor wraps or sits on a face, with
    // full-scale differences on each axis.
    add_write(origin, 16'sh7FFF, 16'sh8000);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_XP), 16'sh7FFF, 16'sh8000);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_XM), 16'sh8000, 16'sh7FFF);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_YP), 16'sh8000, 16'sh8000);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_YM), 16'sh7FFF, 16'sh7FFF);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_ZP), 16'sh0000, 16'sh7FFF);
    add_write(stencil_cell(origin, cfpv_pkg::SLOT_ZM), 16'sh0000, 16'sh8000);
    add_query(origin);
    // smallest nonzero centre: largest gradients
    add_write(origin, 16'sh0001, 16'sh0000);
    add_query(origin);
    // zero centre: velocities forced to zero and the flag raised
    add_write(origin, 16'sh0000, 16'sh0000);
    add_query(origin);
    // most negative centre
    add_write(origin, 16'sh8000, 16'sh0000);
    add_query(origin);
    ready_pts.push_back(origin);
    // far corner: all-ones coordinates, neighbors wrap the other way
    add_stencil(corner, 16'sh0000, 16'sh0001);

    run_phase(24'hFFFFFF, 0, 0, 1'b0);
    run_phase(24'h000000, 76, 0, 1'b0);
    run_phase(GAIN_W'($urandom), 0, 76, 1'b0);
    run_phase(24'h000001, 31, 31, 1'b0);
    run_phase(GAIN_W'($urandom_range(65535, 16)), 0, 0, 1'b1);
    settle();

    fail_count += velocity_due.size();
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
